FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the tacho and speed pulse generator.
// ----------------------------------------------------------------------------
package tsp_pkg;

   // field widths
   localparam int CMD_W      = 2;
   localparam int RPM_W      = 16;
   localparam int SPEED_Q4_W = 13;
   localparam int PPK_W      = 16;
   localparam int FACTOR_W   = 24;
   localparam int TACHO_W    = 24;
   localparam int SPEED_W    = 26;
   localparam int DIV_W      = 29;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // item commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TACHO = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SPEED = 2'd2;

   // register indexes
   localparam logic [1:0] REG_PPK    = 2'd0;
   localparam logic [1:0] REG_FACTOR = 2'd1;
   localparam logic [1:0] REG_MAXRPM = 2'd2;

   // register reset values
   localparam logic [PPK_W-1:0]    PPK_RESET    = 16'd2548;
   localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd150000;
   localparam logic [RPM_W-1:0]    MAXRPM_RESET = 16'd65535;

   // speed conversion
   localparam logic [SPEED_Q4_W-1:0] SPEED_MIN_Q4    = 13'd8;
   localparam logic [DIV_W-1:0]      SPEED_NUMERATOR = 29'd288000000;
   localparam logic [TACHO_W-1:0]    TACHO_MAX       = {TACHO_W{1'b1}};
   localparam logic [SPEED_W-1:0]    SPEED_MAX       = {SPEED_W{1'b1}};

   // classified operations
   typedef enum logic [2:0] {
      OP_NOP        = 3'd0,
      OP_TICK       = 3'd1,
      OP_TACHO_STOP = 3'd2,
      OP_TACHO_DIV  = 3'd3,
      OP_SPEED_STOP = 3'd4,
      OP_SPEED_DIV  = 3'd5
   } op_type;

   // one queued operation: divisor rides along for the divide ops
   typedef struct packed {
      op_type           op;
      logic [DIV_W-1:0] divisor;
   } tsp_op_type;

endpackage

FILE: sv/tsp_front.sv
// ----------------------------------------------------------------------------
// tsp_front
// Accepts items, classifies them and forms the divisor for set commands.
// ----------------------------------------------------------------------------
module tsp_front (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [tsp_pkg::CMD_W-1:0]        req_command,
   input  logic [tsp_pkg::RPM_W-1:0]        req_rpm,
   input  logic [tsp_pkg::SPEED_Q4_W-1:0]   req_speed_q4,
   input  logic [tsp_pkg::PPK_W-1:0]        pulses_per_km,
   input  logic [tsp_pkg::RPM_W-1:0]        max_rpm,
   input  logic                             queue_full,
   output logic                             push,
   output tsp_pkg::tsp_op_type              push_data
);

   logic [tsp_pkg::RPM_W-1:0] rpm_clip;
   logic [tsp_pkg::DIV_W-1:0] speed_prod;

   // clip and product; the queue register follows the multiplier
   assign rpm_clip   = (req_rpm > max_rpm) ? max_rpm : req_rpm;
   assign speed_prod = tsp_pkg::DIV_W'(req_speed_q4) * tsp_pkg::DIV_W'(pulses_per_km);

   // handshake
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // classify the command
   always_comb begin
      push_data.op      = tsp_pkg::OP_NOP;
      push_data.divisor = '0;
      unique case (req_command)
         tsp_pkg::CMD_TICK: begin
            push_data.op = tsp_pkg::OP_TICK;
         end
         tsp_pkg::CMD_TACHO: begin
            if (req_rpm == '0) begin
               push_data.op = tsp_pkg::OP_TACHO_STOP;
            end else begin
               push_data.op      = tsp_pkg::OP_TACHO_DIV;
               push_data.divisor = tsp_pkg::DIV_W'(rpm_clip);
            end
         end
         tsp_pkg::CMD_SPEED: begin
            if (req_speed_q4 < tsp_pkg::SPEED_MIN_Q4) begin
               push_data.op = tsp_pkg::OP_SPEED_STOP;
            end else begin
               push_data.op      = tsp_pkg::OP_SPEED_DIV;
               push_data.divisor = speed_prod;
            end
         end
         default: begin
            push_data.op = tsp_pkg::OP_NOP;
         end
      endcase
   end

endmodule

FILE: sv/tsp_queue.sv
// ----------------------------------------------------------------------------
// tsp_queue
// Short first-in first-out queue of classified operations.
// ----------------------------------------------------------------------------
module tsp_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tsp_pkg::tsp_op_type push_data,
   output logic                full,
   input  logic                pop,
   output tsp_pkg::tsp_op_type pop_data,
   output logic                empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsp_pkg::tsp_op_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // checks
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
                    (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push lost");

endmodule

FILE: sv/tsp_back.sv
// ----------------------------------------------------------------------------
// tsp_back
// Carries out operations: channel ticks, stops and half-period divides.
// ----------------------------------------------------------------------------
module tsp_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [tsp_pkg::FACTOR_W-1:0]       tacho_factor,
   input  logic                               queue_empty,
   input  tsp_pkg::tsp_op_type                pop_data,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_tacho_level,
   output logic                               rsp_speed_level
);

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_DIV = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tsp_pkg::TACHO_W-1:0]       tacho_half_ff, tacho_half_in;
   logic [tsp_pkg::TACHO_W-1:0]       tacho_cnt_ff, tacho_cnt_in;
   logic                              tacho_lvl_ff, tacho_lvl_in;
   logic [tsp_pkg::SPEED_W-1:0]       speed_half_ff, speed_half_in;
   logic [tsp_pkg::SPEED_W-1:0]       speed_cnt_ff, speed_cnt_in;
   logic                              speed_lvl_ff, speed_lvl_in;
   logic [tsp_pkg::DIV_W-1:0]         rem_ff, rem_in;
   logic [tsp_pkg::DIV_W-1:0]         quo_ff, quo_in;
   logic [tsp_pkg::DIV_W-1:0]         dsr_ff, dsr_in;
   logic [tsp_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                              to_speed_ff, to_speed_in;

   logic                              out_free;
   logic                              rsp_take;
   logic [tsp_pkg::TACHO_W:0]         tacho_inc;
   logic [tsp_pkg::SPEED_W:0]         speed_inc;
   logic [tsp_pkg::DIV_W:0]           rem_shift;
   logic                              rem_ge;
   logic [tsp_pkg::DIV_W-1:0]         quo_next;
   logic [tsp_pkg::DIV_W-1:0]         rem_next;
   logic                              div_last;

   assign rsp_take        = rsp_valid_ff && !rsp_stall;
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign pop             = (state_ff == ST_RUN) && !queue_empty && out_free;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tacho_level = tacho_lvl_ff;
   assign rsp_speed_level = speed_lvl_ff;

   // channel increments
   assign tacho_inc = {1'b0, tacho_cnt_ff} + 1'b1;
   assign speed_inc = {1'b0, speed_cnt_ff} + 1'b1;

   // one restoring divide step
   assign rem_shift = {rem_ff, quo_ff[tsp_pkg::DIV_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, dsr_ff};
   assign rem_next  = rem_ge ? tsp_pkg::DIV_W'(rem_shift - {1'b0, dsr_ff})
                             : rem_shift[tsp_pkg::DIV_W-1:0];
   assign quo_next  = {quo_ff[tsp_pkg::DIV_W-2:0], rem_ge};
   assign div_last  = (cnt_ff == tsp_pkg::DIV_CNT_W'(tsp_pkg::DIV_W - 1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_take ? 1'b0 : rsp_valid_ff;
      tacho_half_in = tacho_half_ff;
      tacho_cnt_in  = tacho_cnt_ff;
      tacho_lvl_in  = tacho_lvl_ff;
      speed_half_in = speed_half_ff;
      speed_cnt_in  = speed_cnt_ff;
      speed_lvl_in  = speed_lvl_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dsr_in        = dsr_ff;
      cnt_in        = cnt_ff;
      to_speed_in   = to_speed_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (pop) begin
               rsp_valid_in = 1'b1;
               case (pop_data.op) inside
                  tsp_pkg::OP_TICK: begin
                     // tacho channel
                     if (tacho_half_ff == '0) begin
                        tacho_cnt_in = '0;
                        tacho_lvl_in = 1'b0;
                     end else if (tacho_inc >= {1'b0, tacho_half_ff}) begin
                        tacho_cnt_in = '0;
                        tacho_lvl_in = !tacho_lvl_ff;
                     end else begin
                        tacho_cnt_in = tacho_inc[tsp_pkg::TACHO_W-1:0];
                     end
                     // speed channel
                     if (speed_half_ff == '0) begin
                        speed_cnt_in = '0;
                        speed_lvl_in = 1'b0;
                     end else if (speed_inc >= {1'b0, speed_half_ff}) begin
                        speed_cnt_in = '0;
                        speed_lvl_in = !speed_lvl_ff;
                     end else begin
                        speed_cnt_in = speed_inc[tsp_pkg::SPEED_W-1:0];
                     end
                  end
                  tsp_pkg::OP_TACHO_STOP: begin
                     tacho_half_in = '0;
                  end
                  tsp_pkg::OP_SPEED_STOP: begin
                     speed_half_in = '0;
                  end
                  tsp_pkg::OP_TACHO_DIV, tsp_pkg::OP_SPEED_DIV: begin
                     if (pop_data.divisor == '0) begin
                        // zero divisor saturates the half period
                        if (pop_data.op == tsp_pkg::OP_SPEED_DIV) begin
                           speed_half_in = tsp_pkg::SPEED_MAX;
                        end else begin
                           tacho_half_in = tsp_pkg::TACHO_MAX;
                        end
                     end else begin
                        // result waits for the divide
                        rsp_valid_in = 1'b0;
                        state_in     = ST_DIV;
                        rem_in       = '0;
                        dsr_in       = pop_data.divisor;
                        cnt_in       = '0;
                        to_speed_in  = (pop_data.op == tsp_pkg::OP_SPEED_DIV);
                        quo_in       = (pop_data.op == tsp_pkg::OP_SPEED_DIV)
                                       ? tsp_pkg::SPEED_NUMERATOR
                                       : tsp_pkg::DIV_W'(tacho_factor);
                     end
                  end
                  default: begin
                     // no operation: levels returned as they are
                  end
               endcase
            end
         end
         ST_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               state_in     = ST_RUN;
               rsp_valid_in = 1'b1;
               if (to_speed_ff) begin
                  if (quo_next == '0) begin
                     speed_half_in = tsp_pkg::SPEED_W'(1);
                  end else if (quo_next > tsp_pkg::DIV_W'(tsp_pkg::SPEED_MAX)) begin
                     speed_half_in = tsp_pkg::SPEED_MAX;
                  end else begin
                     speed_half_in = quo_next[tsp_pkg::SPEED_W-1:0];
                  end
               end else begin
                  tacho_half_in = quo_next[tsp_pkg::TACHO_W-1:0];
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_RUN;
         rsp_valid_ff  <= 1'b0;
         tacho_half_ff <= '0;
         tacho_cnt_ff  <= '0;
         tacho_lvl_ff  <= 1'b0;
         speed_half_ff <= '0;
         speed_cnt_ff  <= '0;
         speed_lvl_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         tacho_half_ff <= tacho_half_in;
         tacho_cnt_ff  <= tacho_cnt_in;
         tacho_lvl_ff  <= tacho_lvl_in;
         speed_half_ff <= speed_half_in;
         speed_cnt_ff  <= speed_cnt_in;
         speed_lvl_ff  <= speed_lvl_in;
      end
   end

   // divider datapath
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dsr_ff      <= dsr_in;
      cnt_ff      <= cnt_in;
      to_speed_ff <= to_speed_in;
   end

   // checks
   assert property (@(posedge clock) disable iff (reset) (state_ff == ST_DIV) |-> !rsp_valid_ff)
      else $error("result pending during divide");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DIV) |-> cnt_ff <= tsp_pkg::DIV_CNT_W'(tsp_pkg::DIV_W - 1))
      else $error("divide step count out of range");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DIV && div_last) |=> state_ff == ST_RUN && rsp_valid_ff)
      else $error("divide finished without result");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_DIV) |=> $stable(tacho_lvl_ff) && $stable(speed_lvl_ff))
      else $error("levels moved during divide");

endmodule

FILE: sv/tacho_speed_pulse_generator.sv
// ----------------------------------------------------------------------------
// tacho_speed_pulse_generator
// Tacho and vehicle speed square-wave generator driven by tick and set items.
//
// Every item returns one result with both output levels after the item. The
// front classifies an item in its accept cycle and queues it; the back takes
// one queued operation per cycle unless it is dividing or a result is held
// by rsp_stall. Tick, stop and ignored items need no divide and stream at
// one per cycle. A set item with a nonzero divisor runs a one-bit-per-cycle
// restoring divider over 29 quotient bits in the back; the queue keeps
// accepting items meanwhile until it fills. The result register holds a
// finished result while the next queued operation waits for it to be taken.
// ----------------------------------------------------------------------------
module tacho_speed_pulse_generator #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tsp_pkg::CMD_W-1:0]           req_command,
   input  logic [tsp_pkg::RPM_W-1:0]           req_rpm,
   input  logic [tsp_pkg::SPEED_Q4_W-1:0]      req_speed_q4,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_tacho_level,
   output logic                                rsp_speed_level,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tsp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tsp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tsp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   logic [tsp_pkg::PPK_W-1:0]    ppk_ff;
   logic [tsp_pkg::FACTOR_W-1:0] factor_ff;
   logic [tsp_pkg::RPM_W-1:0]    maxrpm_ff;
   logic                         csr_write;
   logic [1:0]                   csr_index;

   logic                         push;
   logic                         pop;
   logic                         queue_full;
   logic                         queue_empty;
   tsp_pkg::tsp_op_type          push_data;
   tsp_pkg::tsp_op_type          pop_data;

   // register port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppk_ff    <= tsp_pkg::PPK_RESET;
         factor_ff <= tsp_pkg::FACTOR_RESET;
         maxrpm_ff <= tsp_pkg::MAXRPM_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tsp_pkg::REG_PPK:    ppk_ff    <= csr_pwdata[tsp_pkg::PPK_W-1:0];
            tsp_pkg::REG_FACTOR: factor_ff <= csr_pwdata[tsp_pkg::FACTOR_W-1:0];
            tsp_pkg::REG_MAXRPM: maxrpm_ff <= csr_pwdata[tsp_pkg::RPM_W-1:0];
            default: begin
               // unmapped address
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (csr_index)
         tsp_pkg::REG_PPK:    csr_prdata = tsp_pkg::CSR_DATA_W'(ppk_ff);
         tsp_pkg::REG_FACTOR: csr_prdata = tsp_pkg::CSR_DATA_W'(factor_ff);
         tsp_pkg::REG_MAXRPM: csr_prdata = tsp_pkg::CSR_DATA_W'(maxrpm_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // front: accept and classify
   tsp_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_rpm       (req_rpm),
      .req_speed_q4  (req_speed_q4),
      .pulses_per_km (ppk_ff),
      .max_rpm       (maxrpm_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_data     (push_data)
   );

   // queue between front and back
   tsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // back: execute and hold the result
   tsp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tacho_factor    (factor_ff),
      .queue_empty     (queue_empty),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_tacho_level (rsp_tacho_level),
      .rsp_speed_level (rsp_speed_level)
   );

endmodule
